// ===== hw/rtl/ssmo_pkg.sv =====
// ============================================================================
// ssmo_pkg: shared definitions for the sine/saw morph oscillator
// Register codes, microcode types, the control program, rounding and the
// elaboration-time builders for the exp2 and sine lookup tables.
// ============================================================================
package ssmo_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int EXP_TABLE_BITS_DEF  = 8;
    localparam int PHASE_BITS_DEF      = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN         = 3'd0,
        CFG_COARSE_TUNE  = 3'd1,
        CFG_FINE_TUNE    = 3'd2,
        CFG_MORPH        = 3'd3,
        CFG_NOTE         = 3'd4,
        CFG_VOICE_ACTIVE = 3'd5,
        CFG_REF_INC      = 3'd6
    } t_cfg_reg;

    localparam logic [15:0] GAIN_RST    = 16'd4096;
    localparam logic [6:0]  NOTE_RST    = 7'd69;
    localparam logic [31:0] REF_INC_RST = 32'd39370534;

    // Reciprocal multipliers for exact division by constants.
    localparam logic [32:0] K_DIV25    = 33'd10486;         // floor(v/25), v < 43690
    localparam logic [32:0] K_DIV3_16  = 33'd43691;         // floor(v/3) >> 17, v < 2^16
    localparam logic [32:0] K_DIV3_32  = 33'h0_AAAA_AAAB;   // floor(v/3) >> 33, v < 2^32

    // Fixed-point constants for the table builders.
    localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Sequencer.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_OUT = 4'd14;

    typedef enum logic [0:0] {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_FINE,
        MUL_OCT,
        MUL_IDX,
        MUL_DIFF,
        MUL_DIV3,
        MUL_INC,
        MUL_SINE,
        MUL_SAW,
        MUL_GAIN
    } t_mul_op;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_PHASE,
        WB_TOTAL,
        WB_OCT,
        WB_IDX,
        WB_MANT,
        WB_INC,
        WB_MIX0,
        WB_MIX1,
        WB_OUT
    } t_wb_op;

    typedef enum logic [0:0] {
        JMP_NONE,
        JMP_VOICE_OFF
    } t_jmp_cond;

    typedef struct packed {
        t_mul_op           mul;
        t_wb_op            wb;
        t_jmp_cond         jmp;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_ucw;

    // Control program. The write-back of a step consumes the product that the
    // multiplier registered in the step before it.
    function automatic t_ucw ucode(input logic [STEP_W-1:0] step);
        t_ucw uw;
        uw = '{mul: MUL_NONE, wb: WB_NONE, jmp: JMP_NONE, target: STEP_OUT, last: 1'b0};
        unique case (step)
            4'd0: begin
                uw.mul = MUL_FINE;
                uw.wb  = WB_PHASE;
                uw.jmp = JMP_VOICE_OFF;
            end
            4'd1:  uw.wb  = WB_TOTAL;
            4'd2:  uw.mul = MUL_OCT;
            4'd3:  uw.wb  = WB_OCT;
            4'd4:  uw.mul = MUL_IDX;
            4'd5:  uw.wb  = WB_IDX;
            4'd6:  uw.mul = MUL_DIFF;
            4'd7:  uw.mul = MUL_DIV3;
            4'd8:  uw.wb  = WB_MANT;
            4'd9:  uw.mul = MUL_INC;
            4'd10: begin
                uw.mul = MUL_SINE;
                uw.wb  = WB_INC;
            end
            4'd11: begin
                uw.mul = MUL_SAW;
                uw.wb  = WB_MIX0;
            end
            4'd12: uw.wb  = WB_MIX1;
            4'd13: uw.mul = MUL_GAIN;
            4'd14: begin
                uw.wb   = WB_OUT;
                uw.last = 1'b1;
            end
            default: uw.last = 1'b1;
        endcase
        return uw;
    endfunction

    // Signed shift right by n with rounding half away from zero.
    function automatic logic signed [39:0] round_away(input logic signed [39:0] v,
                                                      input int n);
        logic [39:0] mag;
        mag = v[39] ? 40'(-v) : 40'(v);
        mag = (mag + (40'd1 << (n - 1))) >> n;
        return v[39] ? -$signed(mag) : $signed(mag);
    endfunction

    // Integer square root of a 64-bit value.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Entry k of the exp2 table, Q1.30: 2^(k / 2^ebits); the entry past the
    // end is exactly 2.0.
    function automatic logic [31:0] exp_entry(input int k, input int ebits);
        logic [63:0] roots [12];
        logic [63:0] p;
        for (int b = 0; b < 12; b++) roots[b] = '0;
        p = Q30_ONE;
        if (k >= (1 << ebits)) return 32'h8000_0000;
        roots[ebits - 1] = isqrt64(64'h1 << 61);
        for (int b = ebits - 1; b > 0; b--) roots[b - 1] = isqrt64(roots[b] << 30);
        for (int b = 0; b < ebits; b++) begin
            if (((k >> b) & 1) != 0) p = (p * roots[b] + (Q30_ONE >> 1)) >> 30;
        end
        return p[31:0];
    endfunction

    // Entry k of the sine table, Q1.20, from a Q2.30 Taylor polynomial
    // evaluated on the first quadrant and mirrored.
    function automatic logic signed [21:0] sine_entry(input int k, input int sbits);
        int          quarter;
        int          quad;
        int          m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [21:0] q;
        quarter = 1 << (sbits - 2);
        quad    = k >> (sbits - 2);
        m       = k & (quarter - 1);
        if (quad == 1 || quad == 3) m = quarter - m;
        x  = (64'(m) * PI_HALF_Q30) >> (sbits - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = 22'((s + 64'd512) >> 10);
        return (quad >= 2) ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== hw/rtl/sine_saw_morph_phase_oscillator_core.sv =====
// ============================================================================
// sine_saw_morph_phase_oscillator_core: phase-accumulator sine/saw oscillator
// The program has 15 microcode steps on the one shared 33x33 multiplier; an
// inactive voice jumps from step 0 to the last step. A new transaction is
// taken only once the program for the previous one has finished.
// Reset: synchronous, active low; phase cleared, registers to defaults.
// ============================================================================
module sine_saw_morph_phase_oscillator_core #(
    parameter int SINE_TABLE_BITS = ssmo_pkg::SINE_TABLE_BITS_DEF,
    parameter int EXP_TABLE_BITS  = ssmo_pkg::EXP_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = ssmo_pkg::PHASE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssmo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssmo_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    // Input sample channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [14:0]               i_pitch_mod,
    input  logic signed [31:0]               i_phase_mod,
    input  logic                             i_phase_restart,

    // Output sample channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [23:0]               o_sample_out
);

    // ------------------------------------------------------------------------
    // Derived sizes.
    // ------------------------------------------------------------------------
    localparam int SINE_N = 1 << SINE_TABLE_BITS;
    localparam int EXP_N  = 1 << EXP_TABLE_BITS;
    localparam int EA_W   = EXP_TABLE_BITS + 1;   // exp table has EXP_N+1 entries
    localparam int POS_W  = 12 + EXP_TABLE_BITS;  // remainder within the octave, scaled
    localparam int POSH_W = EXP_TABLE_BITS + 2;   // that value divided by 1024
    localparam logic signed [7:0] SH_BIAS = 8'(PHASE_BITS - 62);

    // ------------------------------------------------------------------------
    // Configuration registers. The port never back-pressures; the user must
    // only issue writes while the core is idle, which the block does not enforce.
    // ------------------------------------------------------------------------
    logic [15:0]        r_gain;
    logic signed [14:0] r_coarse;
    logic signed [7:0]  r_fine;
    logic [16:0]        r_morph;
    logic [6:0]         r_note;
    logic               r_voice_active;
    logic [31:0]        r_ref_inc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain         <= ssmo_pkg::GAIN_RST;
            r_coarse       <= '0;
            r_fine         <= '0;
            r_morph        <= '0;
            r_note         <= ssmo_pkg::NOTE_RST;
            r_voice_active <= 1'b0;
            r_ref_inc      <= ssmo_pkg::REF_INC_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ssmo_pkg::t_cfg_reg'(i_cfg_index))
                ssmo_pkg::CFG_GAIN:         r_gain         <= i_cfg_data[15:0];
                ssmo_pkg::CFG_COARSE_TUNE:  r_coarse       <= $signed(i_cfg_data[14:0]);
                ssmo_pkg::CFG_FINE_TUNE:    r_fine         <= $signed(i_cfg_data[7:0]);
                ssmo_pkg::CFG_MORPH:        r_morph        <= i_cfg_data[16:0];
                ssmo_pkg::CFG_NOTE:         r_note         <= i_cfg_data[6:0];
                ssmo_pkg::CFG_VOICE_ACTIVE: r_voice_active <= i_cfg_data[0];
                ssmo_pkg::CFG_REF_INC:      r_ref_inc      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Lookup tables. Both are constant and built at elaboration; reads are
    // registered like a synchronous ROM. The exp2 table holds 2^(k/2^E) in
    // Q1.30 with one extra entry (2.0) so that interpolation never wraps.
    // ------------------------------------------------------------------------
    logic [31:0]        exp_rom  [EXP_N+1];
    logic signed [21:0] sine_rom [SINE_N];

    for (genvar gk = 0; gk <= EXP_N; gk++) begin : g_exp_rom
        localparam logic [31:0] EXP_VAL = ssmo_pkg::exp_entry(gk, EXP_TABLE_BITS);
        assign exp_rom[gk] = EXP_VAL;
    end

    for (genvar gk = 0; gk < SINE_N; gk++) begin : g_sine_rom
        localparam logic signed [21:0] SINE_VAL = ssmo_pkg::sine_entry(gk, SINE_TABLE_BITS);
        assign sine_rom[gk] = SINE_VAL;
    end

    // ------------------------------------------------------------------------
    // Sequencer state. An accepted transaction starts the microcode program at
    // step 0. Every step advances unconditionally except the last, which waits
    // until the output register can take the new sample.
    // ------------------------------------------------------------------------
    ssmo_pkg::t_seq_state    r_state;
    ssmo_pkg::t_seq_state    n_state;
    logic [ssmo_pkg::STEP_W-1:0] r_step;
    logic [ssmo_pkg::STEP_W-1:0] n_step;
    ssmo_pkg::t_ucw          ucw;

    logic in_accept;
    logic out_free;
    logic adv;
    logic wr_out;
    logic jmp_taken;

    logic               r_out_valid;
    logic signed [23:0] r_out;

    assign ucw       = ssmo_pkg::ucode(r_step);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;

    // Outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != ssmo_pkg::SEQ_IDLE);
        adv        = (r_state == ssmo_pkg::SEQ_RUN) && (!ucw.last || out_free);
        wr_out     = adv && (ucw.wb == ssmo_pkg::WB_OUT);
        unique case (ucw.jmp)
            ssmo_pkg::JMP_VOICE_OFF: jmp_taken = !r_voice_active;
            ssmo_pkg::JMP_NONE:      jmp_taken = 1'b0;
            default:                 jmp_taken = 1'b0;
        endcase
    end

    // Next state and step.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ssmo_pkg::SEQ_IDLE: begin
                n_step = '0;
                if (in_accept) n_state = ssmo_pkg::SEQ_RUN;
            end
            ssmo_pkg::SEQ_RUN: begin
                if (adv) begin
                    priority if (ucw.last) begin
                        n_state = ssmo_pkg::SEQ_IDLE;
                        n_step  = '0;
                    end else if (jmp_taken) begin
                        n_step = ucw.target;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ssmo_pkg::SEQ_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssmo_pkg::SEQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------------
    logic [PHASE_BITS-1:0] r_phase;      // accumulator, Q0.PHASE_BITS cycles
    logic [PHASE_BITS-1:0] r_ph;         // accumulator plus phase offset
    logic [PHASE_BITS-1:0] r_inc;        // increment for this sample
    logic signed [14:0]    r_pitch_mod;
    logic [31:0]           r_phase_mod;
    logic signed [21:0]    r_sine;
    logic signed [16:0]    r_total;      // pitch offset from A4, Q8.8 semitones
    logic signed [6:0]     r_oct;        // whole octaves of that offset
    logic [11:0]           r_r;          // remainder within the octave, Q4.8
    logic [11:0]           r_rem;        // interpolation weight, out of 3072
    logic [31:0]           r_exp_lo;
    logic [31:0]           r_exp_hi;
    logic [31:0]           r_mant;       // interpolated 2^frac, Q1.30
    logic signed [38:0]    r_mix_acc;
    logic signed [22:0]    r_mix;        // cross-faded wave, Q1.20
    logic signed [65:0]    r_prod;       // shared multiplier output

    // Phase offset aligned to the accumulator width.
    logic [PHASE_BITS-1:0] pmod;
    logic [20:0]           saw_bits;

    if (PHASE_BITS >= 32) begin : g_pmod_wide
        assign pmod = PHASE_BITS'(r_phase_mod) << (PHASE_BITS - 32);
    end else begin : g_pmod_narrow
        assign pmod = r_phase_mod[31 -: PHASE_BITS];
    end

    if (PHASE_BITS >= 21) begin : g_saw_wide
        assign saw_bits = r_ph[PHASE_BITS-1 -: 21];
    end else begin : g_saw_narrow
        assign saw_bits = 21'(r_ph) << (21 - PHASE_BITS);
    end

    // Combinational helpers, one per microcode write-back.
    logic [7:0]               fine_abs;
    logic [13:0]              fine_num;      // |cents| * 64 + 12
    logic [16:0]              fine_mag;
    logic signed [16:0]       fine_q;
    logic signed [16:0]       note_term;
    logic signed [16:0]       total_nxt;
    logic signed [6:0]        q1;            // offset divided by 1024, floored
    logic [7:0]               qp;            // q1 plus a positive bias that is a multiple of 3
    logic signed [6:0]        oct_nxt;
    logic signed [8:0]        oct_rem;
    logic [POS_W-1:0]         pos;
    logic [POSH_W-1:0]        posh;
    logic [EXP_TABLE_BITS-1:0] idx_nxt;
    logic [POS_W-1:0]         idx_scaled;
    logic [11:0]              rem_nxt;
    logic signed [7:0]        shamt;
    logic [63:0]              inc_full;
    logic [16:0]              morph_p;
    logic [16:0]              morph_inv;
    logic signed [21:0]       saw;
    logic signed [39:0]       mix_rnd;
    logic signed [39:0]       y_rnd;
    logic signed [23:0]       y_sat;

    always_comb begin
        // Fine tune in cents to Q8.8: round(cents * 256 / 100), half away
        // from zero, as a reciprocal multiply by 1/25.
        fine_abs  = r_fine[7] ? 8'(-r_fine) : 8'(r_fine);
        fine_num  = 14'({fine_abs, 6'b0}) + 14'd12;
        fine_mag  = 17'(r_prod[26:18]);
        fine_q    = r_fine[7] ? -$signed(fine_mag) : $signed(fine_mag);
        note_term = 17'(($signed({10'b0, r_note}) - 17'sd69) <<< 8);
        total_nxt = note_term + 17'(r_coarse) + fine_q + 17'(r_pitch_mod);

        // Floor division of the offset by 3072 (one octave in Q8.8): shift
        // by 1024, then divide a small biased value by three.
        q1      = $signed(r_total[16:10]);
        qp      = 8'($signed({q1[6], q1}) + 8'sd66);
        oct_nxt = $signed({1'b0, r_prod[22:17]}) - 7'sd22;
        oct_rem = 9'(q1) - 9'(oct_nxt) - (9'(oct_nxt) <<< 1);

        // Table position within the octave: index and interpolation weight.
        pos        = POS_W'(r_r) << EXP_TABLE_BITS;
        posh       = pos[POS_W-1:10];
        idx_nxt    = r_prod[17 +: EXP_TABLE_BITS];
        idx_scaled = (POS_W'(idx_nxt) << 11) + (POS_W'(idx_nxt) << 10);
        rem_nxt    = 12'(pos - idx_scaled);

        // The product is in Q62 phase units; scale by the octave into accumulator units.
        // Shifts of 64 or more clear the increment entirely.
        shamt = $signed({r_oct[6], r_oct}) + SH_BIAS;
        if (shamt[7]) begin
            inc_full = r_prod[63:0] >> 8'(-shamt);
        end else begin
            inc_full = r_prod[63:0] << shamt;
        end

        // Cross-fade weights; positions beyond one act as pure saw.
        morph_p   = (r_morph > 17'h10000) ? 17'h10000 : r_morph;
        morph_inv = 17'(18'h10000 - {1'b0, morph_p});
        saw       = $signed({1'b0, saw_bits}) - 22'sd1048576;

        mix_rnd = ssmo_pkg::round_away(40'(r_mix_acc) + 40'($signed(r_prod[38:0])), 16);
        y_rnd   = ssmo_pkg::round_away($signed(r_prod[39:0]), 12);
        priority if (y_rnd > 40'sd8388607) begin
            y_sat = 24'sh7FFFFF;
        end else if (y_rnd < -40'sd8388608) begin
            y_sat = -24'sh800000;
        end else begin
            y_sat = y_rnd[23:0];
        end
    end

    // Shared multiplier operand selection.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;

    always_comb begin
        unique case (ucw.mul)
            ssmo_pkg::MUL_FINE: begin
                mul_a = $signed(33'(fine_num));
                mul_b = $signed(ssmo_pkg::K_DIV25);
            end
            ssmo_pkg::MUL_OCT: begin
                mul_a = $signed(33'(qp));
                mul_b = $signed(ssmo_pkg::K_DIV3_16);
            end
            ssmo_pkg::MUL_IDX: begin
                mul_a = $signed(33'(posh));
                mul_b = $signed(ssmo_pkg::K_DIV3_16);
            end
            ssmo_pkg::MUL_DIFF: begin
                mul_a = $signed(33'(r_exp_hi - r_exp_lo));
                mul_b = $signed(33'(r_rem));
            end
            ssmo_pkg::MUL_DIV3: begin
                mul_a = $signed(33'(r_prod[41:10]));
                mul_b = $signed(ssmo_pkg::K_DIV3_32);
            end
            ssmo_pkg::MUL_INC: begin
                mul_a = $signed(33'(r_ref_inc));
                mul_b = $signed(33'(r_mant));
            end
            ssmo_pkg::MUL_SINE: begin
                mul_a = $signed(33'(morph_inv));
                mul_b = 33'(r_sine);
            end
            ssmo_pkg::MUL_SAW: begin
                mul_a = $signed(33'(morph_p));
                mul_b = 33'(saw);
            end
            ssmo_pkg::MUL_GAIN: begin
                mul_a = $signed(33'(r_gain));
                mul_b = 33'(r_mix);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The product register only moves on steps that multiply, so a product
    // stays put for the write-back of the following step, including while the
    // final step waits on the output.
    always_ff @(posedge i_clk) begin
        if (adv && (ucw.mul != ssmo_pkg::MUL_NONE)) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Sine ROM read follows the modulated phase every cycle; r_ph settles in
    // step 0 and the sine value is consumed many steps later.
    always_ff @(posedge i_clk) begin
        r_sine <= sine_rom[r_ph[PHASE_BITS-1 -: SINE_TABLE_BITS]];
    end

    // Input capture and the phase accumulator. A restart clears the phase at
    // the moment the transaction is taken, even for an inactive voice; the
    // accumulator only advances at the final step of an active voice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (in_accept && i_phase_restart) begin
            r_phase <= '0;
        end else if (wr_out && r_voice_active) begin
            r_phase <= r_phase + r_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pitch_mod <= i_pitch_mod;
            r_phase_mod <= i_phase_mod;
        end
    end

    // Microcode write-backs.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            unique case (ucw.wb)
                ssmo_pkg::WB_PHASE: r_ph <= r_phase + pmod;
                ssmo_pkg::WB_TOTAL: r_total <= total_nxt;
                ssmo_pkg::WB_OCT: begin
                    r_oct <= oct_nxt;
                    r_r   <= {oct_rem[1:0], r_total[9:0]};
                end
                ssmo_pkg::WB_IDX: begin
                    r_rem    <= rem_nxt;
                    r_exp_lo <= exp_rom[EA_W'(idx_nxt)];
                    r_exp_hi <= exp_rom[EA_W'(idx_nxt) + EA_W'(1)];
                end
                ssmo_pkg::WB_MANT: r_mant <= r_exp_lo + r_prod[64:33];
                ssmo_pkg::WB_INC:  r_inc <= inc_full[PHASE_BITS-1:0];
                ssmo_pkg::WB_MIX0: r_mix_acc <= $signed(r_prod[38:0]);
                ssmo_pkg::WB_MIX1: r_mix <= 23'(mix_rnd);
                ssmo_pkg::WB_OUT:  r_out <= r_voice_active ? y_sat : '0;
                default: ;
            endcase
        end
    end

    // Output register: the sequencer can take the next transaction while a
    // finished sample is still waiting here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssmo_pkg::SEQ_IDLE) |-> (r_step == '0))
        else $error("sequencer idle with a nonzero step");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ((r_state == ssmo_pkg::SEQ_RUN) && (r_step == '0)))
        else $error("accepted transaction did not start the program");

    a_valid_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(wr_out))
        else $error("output valid raised without a final step");

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_out && !r_voice_active) |=> (o_sample_out == '0))
        else $error("inactive voice produced a nonzero sample");

endmodule

// ===== dv/tb_sine_saw_morph_phase_oscillator_core.sv =====
// ============================================================================
// tb_sine_saw_morph_phase_oscillator_core: self-checking oscillator testbench
// Drives sample transactions and register writes into the core, predicts each
// output sample with a bit-exact model of the phase accumulator, the exp2
// pitch path and the sine/saw crossfade, and checks every output transaction
// in order. The input sees random gaps and the output random stalls.
// ============================================================================
module tb_sine_saw_morph_phase_oscillator_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Table sizes and run limits. The core takes a new sample only once it has
    // finished the program for the previous one.
    localparam int          SINE_BITS    = 10;
    localparam int          EXP_BITS     = 8;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          RANDOM_ITEMS = 600;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          MAX_PRINTED  = 40;

    typedef struct packed {
        logic signed [14:0] pitch;
        logic        [31:0] pmod;
        logic               restart;
    } t_osc_item;

    // DUT connections, every input driven to a known value from time zero.
    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_cfg_valid     = 1'b0;
    logic                                o_cfg_ready;
    logic [ssmo_pkg::CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic [ssmo_pkg::CFG_DATA_W-1:0]     i_cfg_data      = '0;
    logic                                i_in_valid      = 1'b0;
    logic                                o_in_stall;
    logic signed [14:0]                  i_pitch_mod     = '0;
    logic signed [31:0]                  i_phase_mod     = '0;
    logic                                i_phase_restart = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall     = 1'b0;
    logic signed [23:0]                  o_sample_out;

    sine_saw_morph_phase_oscillator_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pitch_mod     (i_pitch_mod),
        .i_phase_mod     (i_phase_mod),
        .i_phase_restart (i_phase_restart),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample_out    (o_sample_out)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Oscillator model: its own lookup tables, register copies and phase.
    // ------------------------------------------------------------------------
    logic [31:0]        exp2_lut [0:(1 << EXP_BITS)];
    int                 sin_lut  [0:(1 << SINE_BITS) - 1];

    logic [15:0]        cfg_gain;
    logic signed [14:0] cfg_coarse;
    logic signed [7:0]  cfg_fine;
    logic [16:0]        cfg_morph;
    logic [6:0]         cfg_note;
    logic               cfg_voice;
    logic [31:0]        cfg_ref_inc;
    logic [31:0]        osc_phase;

    t_osc_item          stim_queue [$];
    logic signed [23:0] sample_expected [$];

    int                 error_count = 0;
    int unsigned        cycle_count = 0;
    int                 gap_left    = 0;
    int                 stall_left  = 0;
    bit                 quiet       = 1'b0;
    logic               in_fire     = 1'b0;
    t_osc_item          drv_item;
    logic signed [23:0] want_sample;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bitv;
        v    = v_in;
        r    = '0;
        bitv = 64'h1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // The exp2 table holds 2^(k/2^EXP_BITS) in Q1.30, built from repeated
    // square roots of two. The sine table is a Taylor polynomial on the first
    // quadrant, mirrored into the other three, rounded to Q1.20.
    task automatic build_tables();
        logic [63:0] root [EXP_BITS];
        logic [63:0] one;
        logic [63:0] p;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        int          quarter;
        int          quad;
        int          m;
        one = 64'h1 << 30;
        root[EXP_BITS - 1] = int_sqrt(64'h1 << 61);
        for (int b = EXP_BITS - 1; b > 0; b--) root[b - 1] = int_sqrt(root[b] << 30);
        for (int k = 0; k < (1 << EXP_BITS); k++) begin
            p = one;
            for (int b = 0; b < EXP_BITS; b++) begin
                if (((k >> b) & 1) != 0) p = (p * root[b] + (one >> 1)) >> 30;
            end
            exp2_lut[k] = p[31:0];
        end
        exp2_lut[1 << EXP_BITS] = 32'h8000_0000;

        quarter = (1 << SINE_BITS) / 4;
        for (int k = 0; k < (1 << SINE_BITS); k++) begin
            quad = k / quarter;
            m    = k % quarter;
            if (quad == 1 || quad == 3) m = quarter - m;
            x  = (64'(m) * 64'd1686629713) / 64'(quarter);
            x2 = (x * x) >> 30;
            t  = one;
            for (int n = 12; n >= 2; n -= 2) t = one - ((x2 * t) >> 30) / 64'(n * (n + 1));
            s  = (x * t) >> 30;
            q  = (s + 64'd512) >> 10;
            sin_lut[k] = (quad >= 2) ? -int'(q) : int'(q);
        end
    endtask

    // Shift right with rounding half away from zero.
    function automatic longint div_round(input longint v, input int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    // Phase increment for the current tuning plus a pitch modulation. The
    // total pitch splits into whole octaves and a position inside the octave;
    // the mantissa is interpolated from the exp2 table and the octave becomes
    // a shift of the 64-bit product. Whatever lands above bit 31 wraps away.
    function automatic logic [31:0] step_increment(input longint pitch);
        longint      cents;
        longint      fine_q;
        longint      total;
        longint      oct;
        longint      r;
        longint      s;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mant;
        logic [63:0] prod;
        cents  = longint'(cfg_fine);
        fine_q = (cents >= 0) ? (cents * 64 + 12) / 25 : -((-cents * 64 + 12) / 25);
        total  = (longint'(cfg_note) - 69) * 256 + longint'(cfg_coarse) + fine_q + pitch;
        oct    = total / 3072;
        r      = total % 3072;
        if (r < 0) begin
            r   = r + 3072;
            oct = oct - 1;
        end
        pos  = 64'(r) << EXP_BITS;
        idx  = pos / 64'd3072;
        rem  = pos % 64'd3072;
        lo   = 64'(exp2_lut[idx]);
        hi   = 64'(exp2_lut[idx + 1]);
        mant = lo + ((hi - lo) * rem) / 64'd3072;
        prod = 64'(cfg_ref_inc) * mant;
        s    = oct - 62 + 32;
        if (s >= 0) return (s >= 64) ? 32'd0 : 32'(prod << s);
        if (-s >= 64) return 32'd0;
        return 32'(prod >> (-s));
    endfunction

    // Expected output for one accepted sample transaction; advances the
    // model phase exactly as the core does.
    function automatic logic signed [23:0] predict_sample(input logic signed [14:0] pitch,
                                                          input logic [31:0] pmod,
                                                          input logic restart);
        logic [31:0] ph;
        longint      sine_v;
        longint      saw_v;
        longint      p;
        longint      mix;
        longint      y;
        // A restart clears the phase even when the voice is off.
        if (restart) osc_phase = '0;
        // A released voice is silent and its phase does not move.
        if (!cfg_voice) return '0;
        ph     = osc_phase + pmod;
        sine_v = sin_lut[ph[31 -: SINE_BITS]];
        saw_v  = longint'(ph[31:11]) - 1048576;
        // Morph positions past one behave as all saw.
        p      = (cfg_morph > 17'd65536) ? 65536 : longint'(cfg_morph);
        mix    = div_round((65536 - p) * sine_v + p * saw_v, 16);
        y      = div_round(longint'(cfg_gain) * mix, 12);
        // Large gains saturate to the 24-bit output range.
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        osc_phase = osc_phase + step_increment(longint'(pitch));
        return 24'(y);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Idle lengths: mostly short, now and then long.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver. A new transaction is presented at the falling edge once
    // the previous one has been taken and its trailing gap has run out; a
    // stalled transaction is held unchanged.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // Still waiting for the core to take it.
        end else if (gap_left != 0) begin
            i_in_valid <= 1'b0;
            gap_left   <= gap_left - 1;
        end else if (stim_queue.size() != 0) begin
            drv_item         = stim_queue.pop_front();
            i_pitch_mod     <= drv_item.pitch;
            i_phase_mod     <= drv_item.pmod;
            i_phase_restart <= drv_item.restart;
            i_in_valid      <= 1'b1;
            gap_left        <= (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output backpressure: random stall bursts; none start during quiet phases.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= idle_len() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. At each rising edge an accepted sample transaction produces a
    // prediction, and an accepted output transaction is checked against the
    // oldest prediction still waiting.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sample_expected.push_back(predict_sample(i_pitch_mod, i_phase_mod,
                                                     i_phase_restart));
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (sample_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected output sample %0d", o_sample_out));
            end else begin
                want_sample = sample_expected.pop_front();
                if (o_sample_out !== want_sample) begin
                    report_mismatch($sformatf("sample_out got %0d expected %0d",
                                              o_sample_out, want_sample));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Register writes, issued from the sequence below only while the core is
    // idle. Bits above a register's width carry random junk.
    // ------------------------------------------------------------------------
    task automatic apply_reg(input ssmo_pkg::t_cfg_reg idx, input logic [31:0] data);
        case (idx)
            ssmo_pkg::CFG_GAIN:         cfg_gain    = data[15:0];
            ssmo_pkg::CFG_COARSE_TUNE:  cfg_coarse  = data[14:0];
            ssmo_pkg::CFG_FINE_TUNE:    cfg_fine    = data[7:0];
            ssmo_pkg::CFG_MORPH:        cfg_morph   = data[16:0];
            ssmo_pkg::CFG_NOTE:         cfg_note    = data[6:0];
            ssmo_pkg::CFG_VOICE_ACTIVE: cfg_voice   = data[0];
            ssmo_pkg::CFG_REF_INC:      cfg_ref_inc = data;
            default: ;
        endcase
    endtask

    task automatic write_reg(input ssmo_pkg::t_cfg_reg idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic program_voice(input logic [15:0] g, input logic [14:0] ct,
                                 input logic [7:0] ft, input logic [16:0] mp,
                                 input logic [6:0] nn, input logic va,
                                 input logic [31:0] ri);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(ssmo_pkg::CFG_GAIN,         {junk[31:16], g});
        write_reg(ssmo_pkg::CFG_COARSE_TUNE,  {junk[16:0], ct});
        write_reg(ssmo_pkg::CFG_FINE_TUNE,    {junk[23:0], ft});
        write_reg(ssmo_pkg::CFG_MORPH,        {junk[14:0], mp});
        write_reg(ssmo_pkg::CFG_NOTE,         {junk[24:0], nn});
        write_reg(ssmo_pkg::CFG_VOICE_ACTIVE, {junk[30:0], va});
        write_reg(ssmo_pkg::CFG_REF_INC,      ri);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random tuning with a fair share of extremes on every register.
    task automatic program_random_voice();
        logic [15:0] g;
        logic [14:0] ct;
        logic [7:0]  ft;
        logic [16:0] mp;
        logic [6:0]  nn;
        logic        va;
        logic [31:0] ri;
        int          pick;
        pick = $urandom_range(0, 9);
        g  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
             (pick < 6) ? 16'($urandom_range(0, 8191)) : 16'($urandom());
        pick = $urandom_range(0, 9);
        ct = (pick == 0) ? 15'h4000 : (pick == 1) ? 15'h3FFF :
             (pick < 6) ? 15'($urandom_range(0, 6144) - 3072) : 15'($urandom());
        pick = $urandom_range(0, 9);
        ft = (pick == 0) ? 8'h80 : (pick == 1) ? 8'h7F :
             (pick < 7) ? 8'($urandom_range(0, 200) - 100) : 8'($urandom());
        pick = $urandom_range(0, 9);
        mp = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 : (pick == 2) ? 17'h1FFFF :
             (pick < 8) ? 17'($urandom_range(0, 65536)) : 17'($urandom());
        pick = $urandom_range(0, 9);
        nn = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 :
             (pick < 6) ? 7'($urandom_range(45, 93)) : 7'($urandom());
        va = ($urandom_range(0, 19) < 17);
        pick = $urandom_range(0, 9);
        ri = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
             (pick < 5) ? ssmo_pkg::REF_INC_RST :
             (pick < 8) ? 32'($urandom_range(1000000, 200000000)) : $urandom();
        program_voice(g, ct, ft, mp, nn, va, ri);
    endtask

    task automatic push_item(input logic [14:0] pitch, input logic [31:0] pmod,
                             input logic restart);
        t_osc_item it;
        it.pitch   = pitch;
        it.pmod    = pmod;
        it.restart = restart;
        stim_queue.push_back(it);
    endtask

    function automatic t_osc_item random_item();
        t_osc_item it;
        int        pick;
        pick = $urandom_range(0, 9);
        it.pitch   = (pick < 5) ? 15'($urandom_range(0, 1536) - 768) :
                     (pick == 5) ? 15'h3FFF : (pick == 6) ? 15'h4000 : 15'($urandom());
        it.pmod    = ($urandom_range(0, 9) < 4) ? 32'd0 : $urandom();
        it.restart = ($urandom_range(0, 19) == 0);
        return it;
    endfunction

    // Wait until every sample has gone through and been checked, then give
    // the core its latency again before touching the registers.
    task automatic settle();
        while (stim_queue.size() != 0 || i_in_valid || sample_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        int random_sent;
        int phase_len;
        build_tables();
        cfg_gain    = ssmo_pkg::GAIN_RST;
        cfg_coarse  = '0;
        cfg_fine    = '0;
        cfg_morph   = '0;
        cfg_note    = ssmo_pkg::NOTE_RST;
        cfg_voice   = 1'b0;
        cfg_ref_inc = ssmo_pkg::REF_INC_RST;
        osc_phase   = '0;

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Default tuning with the voice on: field extremes and a restart.
        quiet = 1'b1;
        program_voice(ssmo_pkg::GAIN_RST, 15'd0, 8'd0, 17'd0, ssmo_pkg::NOTE_RST, 1'b1,
                      ssmo_pkg::REF_INC_RST);
        push_item(15'd0, 32'd0, 1'b1);
        push_item(15'd0, 32'd0, 1'b0);
        push_item(15'h3FFF, 32'h7FFF_FFFF, 1'b0);
        push_item(15'h4000, 32'h8000_0000, 1'b0);
        push_item(15'd0, 32'hFFFF_FFFF, 1'b0);
        settle();

        // Top of every register: gain overflow, morph past one, fine tune
        // above the nominal range, the highest note and the largest increment.
        quiet = 1'b0;
        program_voice(16'hFFFF, 15'h3FFF, 8'h7F, 17'h1FFFF, 7'd127, 1'b1, 32'hFFFF_FFFF);
        push_item(15'h3FFF, 32'h4000_0000, 1'b0);
        push_item(15'h3FFF, 32'hC000_0000, 1'b0);
        push_item(15'h4000, 32'h1234_5678, 1'b0);
        push_item(15'd0, 32'd0, 1'b0);
        settle();

        // Bottom of most registers: zero gain, all-saw morph, lowest note,
        // fine tune below the nominal range and a zero reference increment.
        program_voice(16'd0, 15'h4000, 8'h80, 17'd65536, 7'd0, 1'b1, 32'd0);
        push_item(15'h4000, 32'h0000_0001, 1'b0);
        push_item(15'h3FFF, 32'hFFFF_FFFE, 1'b1);
        settle();
        program_voice(16'd4096, 15'h4000, 8'h80, 17'd65536, 7'd0, 1'b1, 32'd0);
        push_item(15'h4000, 32'h0000_0001, 1'b0);
        settle();

        // Released voice: silent output, phase held, restart still clears it.
        program_voice(ssmo_pkg::GAIN_RST, 15'd0, 8'd0, 17'd32768, ssmo_pkg::NOTE_RST, 1'b0,
                      ssmo_pkg::REF_INC_RST);
        push_item(15'd100, 32'h5555_5555, 1'b0);
        push_item(15'd0, 32'd0, 1'b1);
        push_item(15'h3FFF, 32'hAAAA_AAAA, 1'b0);
        settle();

        // Voice on again: the first sample must start from the cleared phase.
        program_voice(ssmo_pkg::GAIN_RST, 15'd0, 8'd0, 17'd32768, ssmo_pkg::NOTE_RST, 1'b1,
                      ssmo_pkg::REF_INC_RST);
        push_item(15'd0, 32'd0, 1'b0);
        push_item(15'd0, 32'd0, 1'b0);
        push_item(15'd0, 32'd0, 1'b0);
        settle();

        // Random phases, each with its own tuning and idling style.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            program_random_voice();
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 50);
            for (int n = 0; n < phase_len; n++) stim_queue.push_back(random_item());
            random_sent += phase_len;
            settle();
        end

        if (sample_expected.size() != 0)
            report_mismatch($sformatf("%0d expected samples never arrived",
                                      sample_expected.size()));
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
